FILE: rtl/cbw_pkg.sv
// ----------------------------------------------------------------------------
// CBOR item walker package
// Shared constants, codes and the classified byte record.
// ----------------------------------------------------------------------------
package cbw_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int IDX_W     = $clog2(MAX_DEPTH);
  localparam int SP_W      = $clog2(MAX_DEPTH + 1);

  localparam logic [4:0] LIMIT_RESET = 5'd16;

  // Event kinds.
  localparam logic [1:0] EV_HEAD    = 2'd0;
  localparam logic [1:0] EV_BREAK   = 2'd1;
  localparam logic [1:0] EV_PAYLOAD = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RESERVED = 3'd1;
  localparam logic [2:0] ERR_INDEF    = 3'd2;
  localparam logic [2:0] ERR_CHUNK    = 3'd3;
  localparam logic [2:0] ERR_DEPTH    = 3'd4;

  // Kinds of open container.
  localparam logic [2:0] KIND_DEF_ARRAY = 3'd0;
  localparam logic [2:0] KIND_DEF_MAP   = 3'd1;
  localparam logic [2:0] KIND_IND_ARRAY = 3'd2;
  localparam logic [2:0] KIND_IND_MAP   = 3'd3;
  localparam logic [2:0] KIND_IND_BYTES = 3'd4;
  localparam logic [2:0] KIND_IND_TEXT  = 3'd5;

  // Major types.
  localparam logic [2:0] MAJOR_UINT   = 3'd0;
  localparam logic [2:0] MAJOR_NINT   = 3'd1;
  localparam logic [2:0] MAJOR_BYTES  = 3'd2;
  localparam logic [2:0] MAJOR_TEXT   = 3'd3;
  localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
  localparam logic [2:0] MAJOR_MAP    = 3'd5;
  localparam logic [2:0] MAJOR_TAG    = 3'd6;
  localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

  // Minor codes.
  localparam logic [4:0] MINOR_ARG1   = 5'd24;
  localparam logic [4:0] MINOR_ARG8   = 5'd27;
  localparam logic [4:0] MINOR_INDEF  = 5'd31;

  localparam logic [7:0] BREAK_BYTE = 8'hFF;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic [2:0] major;
    logic [4:0] minor;
    logic       is_break;
    logic       minor_rsv;
    logic       minor_indef;
    logic       minor_ext;
  } item_t;

endpackage

FILE: rtl/cbw_front.sv
// ----------------------------------------------------------------------------
// CBOR item walker front end
// Accepts stream bytes, splits them into major and minor fields and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cbw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_stall,
  input  logic [7:0]     data_byte,
  input  logic           restart,
  output logic           item_valid,
  output cbw_pkg::item_t item,
  input  logic           item_pop
);

  cbw_pkg::item_t slots [2];
  cbw_pkg::item_t cls;
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           push;

  assign byte_stall = (count == 2'd2);
  assign push       = byte_valid && !byte_stall;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];

  always_comb begin
    cls.restart     = restart;
    cls.data        = data_byte;
    cls.major       = data_byte[7:5];
    cls.minor       = data_byte[4:0];
    cls.is_break    = (data_byte == cbw_pkg::BREAK_BYTE);
    cls.minor_indef = (data_byte[4:0] == cbw_pkg::MINOR_INDEF);
    cls.minor_rsv   = (data_byte[4:0] > cbw_pkg::MINOR_ARG8) &&
                      (data_byte[4:0] < cbw_pkg::MINOR_INDEF);
    cls.minor_ext   = (data_byte[4:0] >= cbw_pkg::MINOR_ARG1) &&
                      (data_byte[4:0] <= cbw_pkg::MINOR_ARG8);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, item_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/cbw_back.sv
// ----------------------------------------------------------------------------
// CBOR item walker back end
// Assembles heads, skips payloads, keeps the container stack and drives the
// event register. Finished stack levels are closed one at a time in S_FIN.
// ----------------------------------------------------------------------------
module cbw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [4:0]     limit,
  input  logic           item_valid,
  input  cbw_pkg::item_t item,
  output logic           item_pop,
  output logic           event_valid,
  input  logic           event_stall,
  output logic [1:0]     event_kind,
  output logic [2:0]     head_major,
  output logic [63:0]    arg_value,
  output logic           indefinite,
  output logic [4:0]     nest_depth,
  output logic           top_done,
  output logic [2:0]     error_code
);

  typedef enum logic [1:0] {S_IDLE, S_FIN, S_EMIT} state_t;

  state_t state;
  state_t state_next;

  logic [63:0] level_rem  [cbw_pkg::MAX_DEPTH];
  logic [2:0]  level_kind [cbw_pkg::MAX_DEPTH];

  logic [cbw_pkg::SP_W-1:0] sp;
  logic [1:0]  phase;
  logic [3:0]  arg_left;
  logic [63:0] accum;
  logic [63:0] payload;
  logic [2:0]  sticky;
  logic [2:0]  head_type;

  logic [1:0]  ev_kind;
  logic [2:0]  ev_major;
  logic [63:0] ev_arg;
  logic        ev_ind;
  logic [4:0]  ev_depth;
  logic        ev_top;
  logic [2:0]  ev_err;

  // Values after a restart has been applied.
  logic [cbw_pkg::SP_W-1:0] sp_e;
  logic [cbw_pkg::SP_W-1:0] sp_dec;
  logic [cbw_pkg::IDX_W-1:0] top_idx;
  logic [cbw_pkg::IDX_W-1:0] push_idx;
  logic [1:0]  phase_e;
  logic [3:0]  left_e;
  logic [3:0]  left_dec;
  logic [63:0] payload_e;
  logic [63:0] payload_dec;
  logic [2:0]  sticky_e;
  logic [2:0]  top_kind;
  logic        in_str;
  logic        top_ind;
  logic        full;
  logic [63:0] acc_shift;
  logic [2:0]  want;

  logic [cbw_pkg::SP_W-1:0] sp_next;
  logic [1:0]  phase_next;
  logic [3:0]  left_next;
  logic [63:0] accum_next;
  logic [63:0] payload_next;
  logic [2:0]  sticky_next;
  logic [2:0]  type_next;
  logic        push_en;
  logic [2:0]  push_kind;
  logic [63:0] push_rem;
  logic [1:0]  ev_kind_next;
  logic [2:0]  ev_major_next;
  logic [63:0] ev_arg_next;
  logic        ev_ind_next;
  logic [2:0]  ev_err_next;
  logic        hd_req;
  logic [63:0] hd_arg;
  logic [2:0]  hd_major;

  logic [cbw_pkg::IDX_W-1:0] fin_idx;
  logic [63:0] fin_dec;
  logic        out_free;

  assign item_pop = item_valid && (state == S_IDLE);
  assign out_free = !event_valid || !event_stall;

  assign sp_e      = item.restart ? '0 : sp;
  assign phase_e   = item.restart ? 2'd0 : phase;
  assign left_e    = item.restart ? 4'd0 : arg_left;
  assign payload_e = item.restart ? 64'd0 : payload;
  assign sticky_e  = item.restart ? cbw_pkg::ERR_NONE : sticky;

  assign sp_dec   = sp_e - cbw_pkg::SP_W'(1);
  assign top_idx  = sp_dec[cbw_pkg::IDX_W-1:0];
  assign push_idx = sp_e[cbw_pkg::IDX_W-1:0];
  assign top_kind = level_kind[top_idx];
  assign in_str   = (sp_e != '0) && (top_kind >= cbw_pkg::KIND_IND_BYTES);
  assign top_ind  = (sp_e != '0) && (top_kind >= cbw_pkg::KIND_IND_ARRAY);
  assign full     = (int'(sp_e) >= int'(limit)) || (int'(sp_e) >= cbw_pkg::MAX_DEPTH);
  assign want     = (top_kind == cbw_pkg::KIND_IND_BYTES) ? cbw_pkg::MAJOR_BYTES
                                                          : cbw_pkg::MAJOR_TEXT;
  assign acc_shift   = {accum[55:0], item.data};
  assign left_dec    = (left_e != 4'd0) ? left_e - 4'd1 : 4'd0;
  assign payload_dec = (payload_e != 64'd0) ? payload_e - 64'd1 : 64'd0;

  assign fin_idx = 
    cbw_pkg::IDX_W'(sp - cbw_pkg::SP_W'(1));
  assign fin_dec = (level_rem[fin_idx] != 64'd0) ? level_rem[fin_idx] - 64'd1 : 64'd0;

  always_comb begin
    sp_next       = sp_e;
    phase_next    = phase_e;
    left_next     = left_e;
    accum_next    = accum;
    payload_next  = payload_e;
    sticky_next   = sticky_e;
    type_next     = head_type;
    push_en       = 1'b0;
    push_kind     = cbw_pkg::KIND_DEF_ARRAY;
    push_rem      = 64'd0;
    ev_kind_next  = cbw_pkg::EV_HEAD;
    ev_major_next = item.major;
    ev_arg_next   = 64'd0;
    ev_ind_next   = 1'b0;
    ev_err_next   = cbw_pkg::ERR_NONE;
    hd_req        = 1'b0;
    hd_arg        = 64'(item.minor);
    hd_major      = item.major;
    state_next    = S_IDLE;

    if (sticky_e != cbw_pkg::ERR_NONE) begin
      state_next = S_IDLE;
    end else if (phase_e == 2'd1) begin
      accum_next = acc_shift;
      left_next  = left_dec;
      if (left_dec == 4'd0) begin
        phase_next = 2'd0;
        hd_req     = 1'b1;
        hd_arg     = acc_shift;
        hd_major   = head_type;
      end
    end else if (phase_e == 2'd2) begin
      payload_next = payload_dec;
      if (payload_dec == 64'd0) begin
        phase_next    = 2'd0;
        ev_kind_next  = cbw_pkg::EV_PAYLOAD;
        ev_major_next = head_type;
        state_next    = in_str ? S_EMIT : S_FIN;
      end
    end else begin
      type_next = item.major;
      if (item.is_break) begin
        ev_major_next = cbw_pkg::MAJOR_SIMPLE;
        ev_ind_next   = 1'b1;
        state_next    = S_FIN;
        if (top_ind) begin
          sp_next      = sp_dec;
          ev_kind_next = cbw_pkg::EV_BREAK;
        end
      end else if (in_str && item.minor_rsv) begin
        ev_err_next = cbw_pkg::ERR_RESERVED;
      end else if (in_str && ((item.major != want) || item.minor_indef)) begin
        ev_err_next = cbw_pkg::ERR_CHUNK;
      end else if (item.minor_rsv) begin
        ev_err_next = cbw_pkg::ERR_RESERVED;
      end else if (item.minor_indef) begin
        if ((item.major == cbw_pkg::MAJOR_UINT) || (item.major == cbw_pkg::MAJOR_NINT) ||
            (item.major == cbw_pkg::MAJOR_TAG)) begin
          ev_err_next = cbw_pkg::ERR_INDEF;
        end else if (full) begin
          ev_err_next = cbw_pkg::ERR_DEPTH;
        end else begin
          push_en = 1'b1;
          unique case (item.major)
            cbw_pkg::MAJOR_BYTES: push_kind = cbw_pkg::KIND_IND_BYTES;
            cbw_pkg::MAJOR_TEXT:  push_kind = cbw_pkg::KIND_IND_TEXT;
            cbw_pkg::MAJOR_ARRAY: push_kind = cbw_pkg::KIND_IND_ARRAY;
            default:              push_kind = cbw_pkg::KIND_IND_MAP;
          endcase
          sp_next     = sp_e + cbw_pkg::SP_W'(1);
          ev_ind_next = 1'b1;
          state_next  = S_EMIT;
        end
      end else if (item.minor_ext) begin
        phase_next = 2'd1;
        left_next  = 4'd1 << item.minor[1:0];
        accum_next = 64'd0;
      end else begin
        accum_next = 64'(item.minor);
        hd_req     = 1'b1;
      end
    end

    if (ev_err_next != cbw_pkg::ERR_NONE) begin
      sticky_next  = ev_err_next;
      ev_kind_next = cbw_pkg::EV_ERROR;
      state_next   = S_EMIT;
    end

    if (hd_req) begin
      ev_major_next = hd_major;
      ev_arg_next   = hd_arg;
      unique case (hd_major)
        cbw_pkg::MAJOR_BYTES, cbw_pkg::MAJOR_TEXT: begin
          if (hd_arg == 64'd0) begin
            state_next = in_str ? S_EMIT : S_FIN;
          end else begin
            payload_next = hd_arg;
            phase_next   = 2'd2;
            state_next   = S_EMIT;
          end
        end
        cbw_pkg::MAJOR_ARRAY, cbw_pkg::MAJOR_MAP: begin
          if (hd_arg == 64'd0) begin
            state_next = S_FIN;
          end else if (full) begin
            ev_arg_next  = 64'd0;
            ev_err_next  = cbw_pkg::ERR_DEPTH;
            sticky_next  = cbw_pkg::ERR_DEPTH;
            ev_kind_next = cbw_pkg::EV_ERROR;
            state_next   = S_EMIT;
          end else begin
            push_en = 1'b1;
            sp_next = sp_e + cbw_pkg::SP_W'(1);
            if (hd_major == cbw_pkg::MAJOR_MAP) begin
              push_kind = cbw_pkg::KIND_DEF_MAP;
              // A doubled pair count that overflows saturates.
              push_rem  = hd_arg[63] ? '1 : {hd_arg[62:0], 1'b0};
            end else begin
              push_kind = cbw_pkg::KIND_DEF_ARRAY;
              push_rem  = hd_arg;
            end
            state_next = S_EMIT;
          end
        end
        cbw_pkg::MAJOR_TAG: state_next = S_EMIT;
        default:            state_next = S_FIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sp          <= '0;
      phase       <= 2'd0;
      arg_left    <= 4'd0;
      accum       <= 64'd0;
      payload     <= 64'd0;
      sticky      <= cbw_pkg::ERR_NONE;
      head_type   <= 3'd0;
      event_valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        event_valid <= 1'b1;
      end else if (event_valid && !event_stall) begin
        event_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_pop) begin
            sp        <= sp_next;
            phase     <= phase_next;
            arg_left  <= left_next;
            accum     <= accum_next;
            payload   <= payload_next;
            sticky    <= sticky_next;
            head_type <= type_next;
            if (push_en) begin
              level_kind[push_idx] <= push_kind;
              level_rem[push_idx]  <= push_rem;
            end
            ev_kind  <= ev_kind_next;
            ev_major <= ev_major_next;
            ev_arg   <= ev_arg_next;
            ev_ind   <= ev_ind_next;
            ev_depth <= 5'(sp_e);
            ev_top   <= 1'b0;
            ev_err   <= ev_err_next;
            state    <= state_next;
          end
        end
        S_FIN: begin
          // Each cycle counts the item against one level and closes it if done.
          if (sp == '0) begin
            ev_top <= 1'b1;
            state  <= S_EMIT;
          end else if (level_kind[fin_idx] >= cbw_pkg::KIND_IND_ARRAY) begin
            state <= S_EMIT;
          end else begin
            level_rem[fin_idx] <= fin_dec;
            if (fin_dec != 64'd0) begin
              state <= S_EMIT;
            end else begin
              sp <= sp - cbw_pkg::SP_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            event_kind  <= ev_kind;
            head_major  <= ev_major;
            arg_value   <= ev_arg;
            indefinite  <= ev_ind;
            nest_depth  <= ev_depth;
            top_done    <= ev_top;
            error_code  <= ev_err;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/cbor_item_walker.sv
// ----------------------------------------------------------------------------
// CBOR item walker
// Walks a CBOR byte stream and reports heads, breaks, payload ends and errors.
// ----------------------------------------------------------------------------
// Bytes enter on data_byte with restart, under byte_valid and byte_stall; a
// byte is taken when byte_valid is high and byte_stall is low. Restart clears
// the container stack, the parse phase and any sticky error before the byte.
// Events leave on event_valid and event_stall with one field per port. Bytes
// that carry argument or payload data give no event until the last of them.
// The depth limit is written through cfg_valid, cfg_ready and depth_limit;
// cfg_ready is always high and writes belong in idle periods.
// A byte passes through the two-entry input queue, the decoder and the event
// register in that order. Bytes that give no event are decoded one per cycle
// while the decoder is idle; a byte that gives an event holds the decoder
// until the event register takes the event. A break or an event that
// finishes an item first passes through the level counter, which closes
// finished stack levels one at a time, and the bytes behind it wait in the
// queue.
// While the receiver stalls, the event register holds, the decoder waits for
// it and the input queue fills and then raises byte_stall.
// Reset empties the queue and the stack and sets the depth limit to 16.
// ----------------------------------------------------------------------------
module cbor_item_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  event_kind,
  output logic [2:0]  head_major,
  output logic [63:0] arg_value,
  output logic        indefinite,
  output logic [4:0]  nest_depth,
  output logic        top_done,
  output logic [2:0]  error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  depth_limit
);

  logic           limit;
  logic [4:0]     limit_reg;
  logic           item_valid;
  logic           item_pop;
  cbw_pkg::item_t item;

  assign cfg_ready = 1'b1;
  assign limit     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= cbw_pkg::LIMIT_RESET;
    end else if (limit) begin
      limit_reg <= depth_limit;
    end
  end

  cbw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .restart    (restart),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  cbw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .limit       (limit_reg),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .head_major  (head_major),
    .arg_value   (arg_value),
    .indefinite  (indefinite),
    .nest_depth  (nest_depth),
    .top_done    (top_done),
    .error_code  (error_code)
  );

endmodule

FILE: rtl/cbw_checker.sv
// ----------------------------------------------------------------------------
// CBOR item walker checker
// Port-level checks on the event stream, bound to the top level.
// ----------------------------------------------------------------------------
module cbw_checker (
  input logic        clk,
  input logic        rst,
  input logic        event_valid,
  input logic        event_stall,
  input logic [1:0]  event_kind,
  input logic [2:0]  head_major,
  input logic [63:0] arg_value,
  input logic        indefinite,
  input logic        top_done,
  input logic [2:0]  error_code
);

  // Error events carry a code and nothing else does.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> ((event_kind == cbw_pkg::EV_ERROR) == (error_code != cbw_pkg::ERR_NONE)))
    else $error("error code does not match event kind");

  // An error never completes an item and carries a zero argument.
  a_err_top: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == cbw_pkg::EV_ERROR) |-> !top_done && (arg_value == 64'd0))
    else $error("error event with item completion or argument");

  // A break closes with major 7 and the indefinite mark.
  a_break: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == cbw_pkg::EV_BREAK) |->
      (head_major == cbw_pkg::MAJOR_SIMPLE) && indefinite && (arg_value == 64'd0))
    else $error("malformed break event");

  // A stalled event holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(arg_value) && $stable(event_kind))
    else $error("stalled event changed");

endmodule

bind cbor_item_walker cbw_checker u_cbw_checker (
  .clk         (clk),
  .rst         (rst),
  .event_valid (event_valid),
  .event_stall (event_stall),
  .event_kind  (event_kind),
  .head_major  (head_major),
  .arg_value   (arg_value),
  .indefinite  (indefinite),
  .top_done    (top_done),
  .error_code  (error_code)
);
